/* hdl/dnws_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnws_pkg
// Types and constants shared by the directional window search and its cells.
// ----------------------------------------------------------------------------
package dnws_pkg;

  // request kinds
  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_QUERY = 1'b1
  } req_kind_t;

  // search directions
  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_t;

  // control states of the top level
  typedef enum logic [1:0] {
    S_IDLE,
    S_ORIGIN,
    S_SCAN,
    S_HOLD
  } state_t;

  // configuration register indexes
  localparam logic CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic CFG_SCREEN_HEIGHT = 1'b1;

  localparam logic [14:0] SCREEN_WIDTH_RESET  = 15'd1920;
  localparam logic [14:0] SCREEN_HEIGHT_RESET = 15'd1080;
  localparam logic [17:0] SCORE_MAX           = 18'h3FFFF;

  // input request
  typedef struct packed {
    logic               req_type;
    logic [5:0]         entry_index;
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic [14:0]        rect_w;
    logic [14:0]        rect_h;
    logic               entry_usable;
    logic [7:0]         entry_skip_flags;
    logic [1:0]         direction;
    logic [7:0]         skip_mask;
  } req_t;

  // result
  typedef struct packed {
    logic        found;
    logic [5:0]  found_index;
    logic [17:0] best_score;
  } rsp_t;

  // entry write broadcast to the cells, with derived edges and centers
  typedef struct packed {
    logic               we;
    logic [5:0]         index;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [16:0] cx;
    logic signed [16:0] cy;
    logic signed [16:0] fx;
    logic signed [16:0] fy;
    logic               usable;
    logic [7:0]         flags;
  } entry_wr_t;

  // query token handed from cell to cell
  typedef struct packed {
    logic               valid;
    logic [1:0]         dir;
    logic [7:0]         mask;
    logic [5:0]         origin;
    logic signed [16:0] o_main;
    logic signed [16:0] o_lead;
    logic signed [16:0] o_sec;
    logic [13:0]        pen;
    logic               have;
    logic [17:0]        best;
    logic [5:0]         best_i;
  } token_t;

  // position plus half the size
  function automatic logic signed [16:0] center17(input logic signed [15:0] pos,
                                                  input logic [14:0] len);
    center17 = {pos[15], pos} + {3'b000, len[14:1]};
  endfunction

  // position plus the full size
  function automatic logic signed [16:0] far17(input logic signed [15:0] pos,
                                               input logic [14:0] len);
    far17 = {pos[15], pos} + {2'b00, len};
  endfunction

endpackage

/* hdl/dnws_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnws_cell
// One table entry: stores its rectangle and scores the passing query token.
// ----------------------------------------------------------------------------
module dnws_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  dnws_pkg::entry_wr_t wr,
  input  dnws_pkg::token_t    tok_in,
  output dnws_pkg::token_t    tok_out
);
  import dnws_pkg::*;

  logic signed [15:0] x;
  logic signed [15:0] y;
  logic signed [16:0] cx;
  logic signed [16:0] cy;
  logic signed [16:0] fx;
  logic signed [16:0] fy;
  logic               usable;
  logic [7:0]         flags;

  logic               vert;
  logic               fwd;
  logic signed [16:0] main_c;
  logic signed [16:0] main_lead;
  logic signed [16:0] sec_lo;
  logic signed [16:0] sec_hi;
  logic signed [16:0] sec_c;
  logic signed [17:0] dmain;
  logic signed [17:0] dpos;
  logic signed [17:0] dsec;
  logic [16:0]        dabs;
  logic               outside;
  logic [18:0]        score_sum;
  logic [17:0]        score;
  logic               eligible;
  logic               take;
  token_t             tok_next;

  // hold the entry; only the usable bit is cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      usable <= 1'b0;
    end else if (wr.we && (int'(wr.index) == CELL_INDEX)) begin
      usable <= wr.usable;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we && (int'(wr.index) == CELL_INDEX)) begin
      x     <= wr.x;
      y     <= wr.y;
      cx    <= wr.cx;
      cy    <= wr.cy;
      fx    <= wr.fx;
      fy    <= wr.fy;
      flags <= wr.flags;
    end
  end

  // pick the axes for the token's direction
  always_comb begin
    vert      = (tok_in.dir == DIR_UP) || (tok_in.dir == DIR_DOWN);
    fwd       = (tok_in.dir == DIR_DOWN) || (tok_in.dir == DIR_RIGHT);
    main_c    = vert ? cy : cx;
    if (fwd) begin
      main_lead = vert ? fy : fx;
    end else begin
      main_lead = vert ? {y[15], y} : {x[15], x};
    end
    sec_lo    = vert ? {x[15], x} : {y[15], y};
    sec_hi    = vert ? fx : fy;
    sec_c     = vert ? cx : cy;
  end

  // score this entry against the origin
  always_comb begin
    if (fwd) begin
      dmain = {main_c[16], main_c} - {tok_in.o_main[16], tok_in.o_main};
      dpos  = {main_lead[16], main_lead} - {tok_in.o_lead[16], tok_in.o_lead};
    end else begin
      dmain = {tok_in.o_main[16], tok_in.o_main} - {main_c[16], main_c};
      dpos  = {tok_in.o_lead[16], tok_in.o_lead} - {main_lead[16], main_lead};
    end
    dsec      = {tok_in.o_sec[16], tok_in.o_sec} - {sec_c[16], sec_c};
    dabs      = dsec[17] ? 17'(-dsec) : dsec[16:0];
    outside   = (tok_in.o_sec < sec_lo) || (tok_in.o_sec > sec_hi);
    score_sum = {2'b00, dmain[16:0]} + (outside ? {5'd0, tok_in.pen} : 19'd0)
              + {2'b00, dabs};
    score     = score_sum[18] ? SCORE_MAX : score_sum[17:0];
    eligible  = tok_in.valid && usable && (CELL_INDEX != int'(tok_in.origin))
              && ((flags & tok_in.mask) == 8'd0)
              && !dmain[17] && !dpos[17] && (dpos != 18'sd0);
    take      = eligible && (!tok_in.have || (score < tok_in.best));
  end

  // keep the first lowest score
  always_comb begin
    tok_next = tok_in;
    if (take) begin
      tok_next.have   = 1'b1;
      tok_next.best   = score;
      tok_next.best_i = 6'(CELL_INDEX);
    end
  end

  // advance the token to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    tok_out.dir    <= tok_next.dir;
    tok_out.mask   <= tok_next.mask;
    tok_out.origin <= tok_next.origin;
    tok_out.o_main <= tok_next.o_main;
    tok_out.o_lead <= tok_next.o_lead;
    tok_out.o_sec  <= tok_next.o_sec;
    tok_out.pen    <= tok_next.pen;
    tok_out.have   <= tok_next.have;
    tok_out.best   <= tok_next.best;
    tok_out.best_i <= tok_next.best_i;
  end

endmodule

/* hdl/directional_nearest_window_search.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// directional_nearest_window_search
// Window table with a directional nearest-neighbor query over a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one request: a table write or a query. Every
//   request gives exactly one result on out_valid/out_ready, in order.
//   cfg_we/cfg_index/cfg_data set screen width (0) and height (1); write
//   them only while no request is in flight.
// Request flow:
//   A write goes from acceptance straight to the hold state; in_ready
//   returns as its result moves into the output register. A query reads
//   its origin from a small memory, builds the query token, and walks the
//   token through the row of MAX_WINDOWS cells, one cell per cycle. Only
//   one request is worked on at a time; in_ready stays low until it is done.
// Reset:
//   Synchronous, active high. Screen size returns to 1920 x 1080 and every
//   entry becomes unusable; rectangles stay undefined until written.
// Stall:
//   One result waits in the output register while the next request is
//   already taken and worked on; that one then waits in a holding register
//   and in_ready stays low until the output frees.
// ----------------------------------------------------------------------------
module directional_nearest_window_search #(
  parameter int MAX_WINDOWS = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  dnws_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output dnws_pkg::rsp_t out_data,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [14:0]    cfg_data
);
  import dnws_pkg::*;

  localparam int IDX_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
  } origin_t;

  state_t      state;
  state_t      state_next;
  logic [14:0] screen_width;
  logic [14:0] screen_height;

  origin_t     origin_mem [MAX_WINDOWS];
  origin_t     mem_q;
  logic [31:0] addr_wide;
  logic [IDX_W-1:0] addr;
  logic        in_range;
  logic        accept;
  logic        is_query;

  logic [1:0]  q_dir;
  logic [7:0]  q_mask;
  logic [5:0]  q_origin;

  entry_wr_t   wr;
  token_t      tok [MAX_WINDOWS+1];
  token_t      tok0_next;
  rsp_t        res;
  logic        scan_done;
  logic        move_out;
  logic        tok0_load;
  logic        q_vert;
  logic        q_fwd;

  assign accept    = in_valid && in_ready;
  assign is_query  = (in_data.req_type == REQ_QUERY);
  assign addr_wide = 32'(in_data.entry_index);
  assign addr      = addr_wide[IDX_W-1:0];
  assign in_range  = (addr_wide < 32'(MAX_WINDOWS));
  assign scan_done = tok[MAX_WINDOWS].valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RESET;
      screen_height <= SCREEN_HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        CFG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (is_query && in_range) ? S_ORIGIN : S_HOLD;
        end
      end
      S_ORIGIN: state_next = S_SCAN;
      S_SCAN: begin
        if (scan_done) state_next = S_HOLD;
      end
      S_HOLD: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = (state == S_IDLE);
    tok0_load = (state == S_ORIGIN);
    move_out  = (state == S_HOLD) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // origin copy of the table; read at the accepting edge
  always_ff @(posedge clk) begin
    if (accept && !is_query && in_range) begin
      origin_mem[addr] <= '{x: in_data.rect_x, y: in_data.rect_y,
                            w: in_data.rect_w, h: in_data.rect_h};
    end
    if (accept) begin
      mem_q <= origin_mem[addr];
    end
  end

  // hold the query fields
  always_ff @(posedge clk) begin
    if (accept) begin
      q_dir    <= in_data.direction;
      q_mask   <= in_data.skip_mask;
      q_origin <= in_data.entry_index;
    end
  end

  // broadcast entry writes to the cells
  always_comb begin
    wr.we     = accept && !is_query && in_range;
    wr.index  = in_data.entry_index;
    wr.x      = in_data.rect_x;
    wr.y      = in_data.rect_y;
    wr.cx     = center17(in_data.rect_x, in_data.rect_w);
    wr.cy     = center17(in_data.rect_y, in_data.rect_h);
    wr.fx     = far17(in_data.rect_x, in_data.rect_w);
    wr.fy     = far17(in_data.rect_y, in_data.rect_h);
    wr.usable = in_data.entry_usable;
    wr.flags  = in_data.entry_skip_flags;
  end

  // build the query token from the origin rectangle
  always_comb begin
    q_vert = (q_dir == DIR_UP) || (q_dir == DIR_DOWN);
    q_fwd  = (q_dir == DIR_DOWN) || (q_dir == DIR_RIGHT);
    tok0_next.valid  = tok0_load;
    tok0_next.dir    = q_dir;
    tok0_next.mask   = q_mask;
    tok0_next.origin = q_origin;
    tok0_next.o_main = q_vert ? center17(mem_q.y, mem_q.h) : center17(mem_q.x, mem_q.w);
    tok0_next.o_sec  = q_vert ? center17(mem_q.x, mem_q.w) : center17(mem_q.y, mem_q.h);
    if (q_fwd) begin
      tok0_next.o_lead = q_vert ? far17(mem_q.y, mem_q.h) : far17(mem_q.x, mem_q.w);
    end else begin
      tok0_next.o_lead = q_vert ? {mem_q.y[15], mem_q.y} : {mem_q.x[15], mem_q.x};
    end
    tok0_next.pen    = q_vert ? screen_height[14:1] : screen_width[14:1];
    tok0_next.have   = 1'b0;
    tok0_next.best   = 18'd0;
    tok0_next.best_i = 6'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0].valid <= 1'b0;
    end else begin
      tok[0].valid <= tok0_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    tok[0].dir    <= tok0_next.dir;
    tok[0].mask   <= tok0_next.mask;
    tok[0].origin <= tok0_next.origin;
    tok[0].o_main <= tok0_next.o_main;
    tok[0].o_lead <= tok0_next.o_lead;
    tok[0].o_sec  <= tok0_next.o_sec;
    tok[0].pen    <= tok0_next.pen;
    tok[0].have   <= tok0_next.have;
    tok[0].best   <= tok0_next.best;
    tok[0].best_i <= tok0_next.best_i;
  end

  // row of entry cells
  for (genvar i = 0; i < MAX_WINDOWS; i++) begin : g_cell
    dnws_cell #(
      .CELL_INDEX(i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .wr      (wr),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  // hold the result of the current request
  always_ff @(posedge clk) begin
    if (accept) begin
      res <= '0;
    end else if ((state == S_SCAN) && scan_done) begin
      res.found       <= tok[MAX_WINDOWS].have;
      res.found_index <= tok[MAX_WINDOWS].have ? tok[MAX_WINDOWS].best_i : 6'd0;
      res.best_score  <= tok[MAX_WINDOWS].have ? tok[MAX_WINDOWS].best : 18'd0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move_out) begin
      out_data <= res;
    end
  end

endmodule
